### rtl/mcn_pkg.sv
// Shared types and constants for the menu cursor key navigator.
package mcn_pkg;

   // Default menu size; the top level hands it down as a parameter.
   localparam int MCN_MAX_ENTRIES = 64;

   // Fixed field widths of the transactions and registers.
   localparam int FUNC_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int KEY_W    = 4;
   localparam int CHAR_W   = 7;
   localparam int CURSOR_W = 6;
   localparam int OUTC_W   = 2;
   localparam int COUNT_W  = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Event selector codes.
   localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SERIAL = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_USAGE  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ITEM_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DISABLED     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_INDEX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SERIAL_EN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEYBOARD_EN  = 3'd4;

   // Serial character codes.
   localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
   localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
   localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
   localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
   localparam logic [BYTE_W-1:0] CH_CSI   = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

   // Keyboard usage codes.
   localparam logic [BYTE_W-1:0] USAGE_ENTER = 8'h28;
   localparam logic [BYTE_W-1:0] USAGE_ESC   = 8'h29;
   localparam logic [BYTE_W-1:0] USAGE_BACK  = 8'h2A;
   localparam logic [BYTE_W-1:0] USAGE_RIGHT = 8'h4F;
   localparam logic [BYTE_W-1:0] USAGE_LEFT  = 8'h50;
   localparam logic [BYTE_W-1:0] USAGE_DOWN  = 8'h51;
   localparam logic [BYTE_W-1:0] USAGE_UP    = 8'h52;

   // Decoded keys.
   typedef enum logic [KEY_W-1:0] {
      KEY_NONE  = 4'd0,
      KEY_UP    = 4'd1,
      KEY_DOWN  = 4'd2,
      KEY_LEFT  = 4'd3,
      KEY_RIGHT = 4'd4,
      KEY_ENTER = 4'd5,
      KEY_ESC   = 4'd6,
      KEY_BACK  = 4'd7,
      KEY_PRINT = 4'd8
   } key_type;

   // Result outcomes.
   typedef enum logic [OUTC_W-1:0] {
      OUT_NAV     = 2'd0,
      OUT_CHOSEN  = 2'd1,
      OUT_CANCEL  = 2'd2,
      OUT_IGNORED = 2'd3
   } outcome_type;

   // Escape sequence phase of the serial decoder.
   typedef enum logic [2:0] {
      PH_NEUTRAL = 3'b001,
      PH_ESC     = 3'b010,
      PH_CSI     = 3'b100
   } phase_type;

   // Top-level sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEEK = 2'b10
   } state_type;

   // Command to the entry seek unit.
   typedef struct packed {
      logic start;
      logic up;
   } seek_req_type;

   // Status of the entry seek unit.
   typedef struct packed {
      logic busy;
      logic done;
   } seek_stat_type;

endpackage

### rtl/mcn_if.sv
// Valid/ready channel interfaces for key events and navigation results.
interface mcn_req_if import mcn_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [BYTE_W-1:0]   byte_value;
   logic                is_press;

   modport source (output valid, func, byte_value, is_press, input ready);
   modport sink   (input valid, func, byte_value, is_press, output ready);
endinterface

interface mcn_rsp_if import mcn_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KEY_W-1:0]    decoded_key;
   logic [CHAR_W-1:0]   printable_char;
   logic [CURSOR_W-1:0] cursor_index;
   logic [OUTC_W-1:0]   outcome;

   modport source (output valid, decoded_key, printable_char, cursor_index, outcome,
                   input ready);
   modport sink   (input valid, decoded_key, printable_char, cursor_index, outcome,
                   output ready);
endinterface

### rtl/menu_cursor_key_navigator_core.sv
// Top level of the menu cursor key navigator.
//
// Key events come in on req_chan (start, serial byte or keyboard usage code) and each
// accepted transaction yields exactly one result transaction on rsp_chan: the decoded
// key, the printable character, the cursor and the outcome.
// Events with no cursor walk (all but start, and up and down while active, on a non-empty
// menu) finish in the accept cycle and their result is valid on the next cycle.
// Start, up and down run the entry seek unit, which examines one menu entry per cycle,
// and at most the effective entry count of entries (itself at most MAX_ENTRIES) before
// the result is made valid.
// One transaction is worked on at a time; req_chan.ready is low while the seek unit runs.
// A finished result waits in the output register; the next transaction is accepted in
// the same cycle that the pending result is taken, so a stalled receiver holds off new
// input but loses nothing.
// The user writes configuration through csr_we, csr_index and csr_wdata only while the
// block is idle; the block does not enforce this. Unknown indexes are ignored.
// Synchronous reset loads the register defaults (one entry, none disabled, serial on,
// keyboard off), clears the cursor, the escape phase and the active flag, and drops any
// pending result. No clearing pass is needed after reset.
module menu_cursor_key_navigator_core import mcn_pkg::*; #(
   parameter int MAX_ENTRIES = MCN_MAX_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   mcn_req_if.sink               req_chan,
   mcn_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // Configuration registers.
   logic [COUNT_W-1:0]     item_count_ff;
   logic [MAX_ENTRIES-1:0] disabled_ff;
   logic [CURSOR_W-1:0]    start_index_ff;
   logic                   serial_en_ff;
   logic                   keyboard_en_ff;

   // Navigation and sequencing state.
   state_type         state_ff;
   state_type         state_in;
   logic [IDX_W-1:0]  cursor_ff;
   logic [IDX_W-1:0]  cursor_in;
   logic              active_ff;
   logic              active_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   key_type           rsp_key_ff;
   key_type           rsp_key_in;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic [CHAR_W-1:0] rsp_char_in;
   logic [IDX_W-1:0]  rsp_cursor_ff;
   logic [IDX_W-1:0]  rsp_cursor_in;
   outcome_type       rsp_outcome_ff;
   outcome_type       rsp_outcome_in;

   logic              accept;
   logic [CNT_W-1:0]  count;
   logic              count_zero;
   logic              src_enabled;
   logic              sel_serial;
   key_type           dec_key;
   logic [CHAR_W-1:0] dec_char;
   key_type           key;
   logic [IDX_W-1:0]  cursor_eff;
   logic [CNT_W-1:0]  cursor_inc;
   logic [IDX_W-1:0]  up_from;
   logic [IDX_W-1:0]  down_from;
   logic [IDX_W-1:0]  start_from;
   logic [IDX_W-1:0]  seek_from;
   logic [IDX_W-1:0]  seek_result;
   seek_req_type      seek_cmd;
   seek_stat_type     seek_stat;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff  <= COUNT_W'(1);
         disabled_ff    <= '0;
         start_index_ff <= '0;
         serial_en_ff   <= 1'b1;
         keyboard_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ITEM_COUNT:  item_count_ff  <= csr_wdata[COUNT_W-1:0];
            REG_DISABLED:    disabled_ff    <= csr_wdata[MAX_ENTRIES-1:0];
            REG_START_INDEX: start_index_ff <= csr_wdata[CURSOR_W-1:0];
            REG_SERIAL_EN:   serial_en_ff   <= csr_wdata[0];
            REG_KEYBOARD_EN: keyboard_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Handshake: accept only when idle and the result slot is free or being emptied.
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   // Effective entry count, clamped to the menu size.
   assign count      = (item_count_ff > COUNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                                : item_count_ff[CNT_W-1:0];
   assign count_zero = (count == '0);

   // Source enable per event kind.
   assign sel_serial  = (req_chan.func == FUNC_SERIAL);
   assign src_enabled = sel_serial ? serial_en_ff
                                   : (req_chan.func == FUNC_USAGE) && keyboard_en_ff;

   mcn_decoder u_decoder (
      .clock          (clock),
      .reset          (reset),
      .byte_value     (req_chan.byte_value),
      .is_press       (req_chan.is_press),
      .sel_serial     (sel_serial),
      .advance        (accept && sel_serial && serial_en_ff),
      .key            (dec_key),
      .printable_char (dec_char)
   );

   assign key = src_enabled ? dec_key : KEY_NONE;

   // A cursor left beyond a shrunk count restarts from the first entry.
   assign cursor_eff = (CNT_W'(cursor_ff) >= count) ? '0 : cursor_ff;
   assign cursor_inc = CNT_W'(cursor_eff) + CNT_W'(1);
   assign up_from    = (cursor_eff == '0) ? IDX_W'(count - CNT_W'(1)) : cursor_eff - IDX_W'(1);
   assign down_from  = (cursor_inc == count) ? '0 : cursor_inc[IDX_W-1:0];
   assign start_from = (COUNT_W'(start_index_ff) < COUNT_W'(count))
                       ? start_index_ff[IDX_W-1:0] : '0;

   // Per-transaction decisions, taken in the accept cycle.
   always_comb begin
      state_in       = state_ff;
      cursor_in      = cursor_ff;
      active_in      = active_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_key_in     = rsp_key_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_cursor_in  = rsp_cursor_ff;
      rsp_outcome_in = rsp_outcome_ff;
      seek_cmd       = '0;
      seek_from      = start_from;

      if (accept) begin
         rsp_key_in     = KEY_NONE;
         rsp_char_in    = '0;
         rsp_cursor_in  = cursor_ff;
         rsp_outcome_in = OUT_IGNORED;
         rsp_valid_in   = 1'b1;
         case (req_chan.func) inside
            FUNC_START: begin
               if (count_zero) begin
                  active_in      = 1'b0;
                  rsp_outcome_in = OUT_CANCEL;
               end else begin
                  active_in      = 1'b1;
                  rsp_outcome_in = OUT_NAV;
                  seek_cmd.start = 1'b1;
                  seek_from      = start_from;
               end
            end
            FUNC_SERIAL, FUNC_USAGE: begin
               if (src_enabled) begin
                  rsp_key_in  = key;
                  rsp_char_in = dec_char;
                  if (active_ff) begin
                     if (count_zero) begin
                        active_in      = 1'b0;
                        rsp_outcome_in = OUT_CANCEL;
                     end else begin
                        cursor_in      = cursor_eff;
                        rsp_cursor_in  = cursor_eff;
                        rsp_outcome_in = OUT_NAV;
                        case (key) inside
                           KEY_UP: begin
                              seek_cmd.start = 1'b1;
                              seek_cmd.up    = 1'b1;
                              seek_from      = up_from;
                           end
                           KEY_DOWN: begin
                              seek_cmd.start = 1'b1;
                              seek_from      = down_from;
                           end
                           KEY_ENTER, KEY_RIGHT: begin
                              if (!disabled_ff[cursor_eff]) begin
                                 rsp_outcome_in = OUT_CHOSEN;
                                 active_in      = 1'b0;
                              end
                           end
                           KEY_ESC, KEY_BACK: begin
                              rsp_outcome_in = OUT_CANCEL;
                              active_in      = 1'b0;
                           end
                           default: ;
                        endcase
                     end
                  end
               end
            end
            default: ;
         endcase
         // A cursor walk holds the result back until the seek unit finishes.
         if (seek_cmd.start) begin
            rsp_valid_in = 1'b0;
            state_in     = ST_SEEK;
         end
      end

      // Seek completion fills in the cursor and releases the result.
      if (seek_stat.done) begin
         cursor_in     = seek_result;
         rsp_cursor_in = seek_result;
         rsp_valid_in  = 1'b1;
         state_in      = ST_IDLE;
      end
   end

   mcn_seeker #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_seeker (
      .clock    (clock),
      .reset    (reset),
      .cmd      (seek_cmd),
      .from     (seek_from),
      .count    (count),
      .disabled (disabled_ff),
      .stat     (seek_stat),
      .result   (seek_result)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_key_ff     <= rsp_key_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_cursor_ff  <= rsp_cursor_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.decoded_key    = rsp_key_ff;
   assign rsp_chan.printable_char = rsp_char_ff;
   assign rsp_chan.cursor_index   = CURSOR_W'(rsp_cursor_ff);
   assign rsp_chan.outcome        = rsp_outcome_ff;

   // No new transaction is taken while the seek unit walks the menu.
   assert property (@(posedge clock) disable iff (reset)
      seek_stat.busy |-> !req_chan.ready)
      else $error("input accepted while a cursor walk is in progress");

   // The result slot stays empty for the whole walk.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEEK) |-> !rsp_valid_ff)
      else $error("result pending during a cursor walk");

   // The seek unit finishes only inside a walk started by the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      seek_stat.done |-> (state_ff == ST_SEEK))
      else $error("seek completion outside a walk");

   // A choice is only ever made by enter or right.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_outcome_ff == OUT_CHOSEN)
         |-> (rsp_key_ff == KEY_ENTER || rsp_key_ff == KEY_RIGHT))
      else $error("entry chosen by a key other than enter or right");

   // A chosen entry closes the menu.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_outcome_ff == OUT_CHOSEN |-> !active_ff)
      else $error("menu still active after a choice");

endmodule

### rtl/mcn_decoder.sv
// Key decoder: serial escape-sequence decoding and keyboard usage mapping.
module mcn_decoder import mcn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] byte_value,
   input  logic              is_press,
   input  logic              sel_serial,
   input  logic              advance,
   output key_type           key,
   output logic [CHAR_W-1:0] printable_char
);

   phase_type         phase_ff;
   phase_type         phase_in;
   key_type           key_serial;
   key_type           key_usage;
   logic [CHAR_W-1:0] char_serial;

   // Serial byte decoding against the current escape phase.
   always_comb begin
      key_serial  = KEY_NONE;
      char_serial = '0;
      phase_in    = phase_ff;
      unique case (phase_ff)
         PH_NEUTRAL: begin
            if (byte_value == CH_ESC) begin
               phase_in = PH_ESC;
            end else if (byte_value == CH_CR || byte_value == CH_LF) begin
               key_serial = KEY_ENTER;
            end else if (byte_value == CH_DEL || byte_value == CH_BS) begin
               key_serial = KEY_BACK;
            end else if (byte_value >= CH_SPACE && byte_value < CH_DEL) begin
               key_serial  = KEY_PRINT;
               char_serial = byte_value[CHAR_W-1:0];
            end
         end
         PH_ESC: begin
            // Anything but a bracket after ESC is a lone escape; the byte is consumed.
            if (byte_value == CH_CSI) begin
               phase_in = PH_CSI;
            end else begin
               phase_in   = PH_NEUTRAL;
               key_serial = KEY_ESC;
            end
         end
         PH_CSI: begin
            phase_in = PH_NEUTRAL;
            unique case (byte_value)
               CH_A:    key_serial = KEY_UP;
               CH_B:    key_serial = KEY_DOWN;
               CH_C:    key_serial = KEY_RIGHT;
               CH_D:    key_serial = KEY_LEFT;
               default: key_serial = KEY_NONE;
            endcase
         end
         default: begin
            phase_in = PH_NEUTRAL;
         end
      endcase
   end

   // Keyboard usage codes map to keys on a press only.
   always_comb begin
      key_usage = KEY_NONE;
      if (is_press) begin
         unique case (byte_value)
            USAGE_UP:    key_usage = KEY_UP;
            USAGE_DOWN:  key_usage = KEY_DOWN;
            USAGE_LEFT:  key_usage = KEY_LEFT;
            USAGE_RIGHT: key_usage = KEY_RIGHT;
            USAGE_ENTER: key_usage = KEY_ENTER;
            USAGE_ESC:   key_usage = KEY_ESC;
            USAGE_BACK:  key_usage = KEY_BACK;
            default:     key_usage = KEY_NONE;
         endcase
      end
   end

   assign key            = sel_serial ? key_serial : key_usage;
   assign printable_char = sel_serial ? char_serial : '0;

   // The escape phase moves only on an accepted, enabled serial byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NEUTRAL;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
   end

endmodule

### rtl/mcn_seeker.sv
// Entry seek unit: steps one menu entry per cycle to the next enabled entry.
module mcn_seeker import mcn_pkg::*; #(
   parameter int MAX_ENTRIES = MCN_MAX_ENTRIES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  seek_req_type                         cmd,
   input  logic [$clog2(MAX_ENTRIES)-1:0]       from,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]     count,
   input  logic [MAX_ENTRIES-1:0]               disabled,
   output seek_stat_type                        stat,
   output logic [$clog2(MAX_ENTRIES)-1:0]       result
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic             busy_ff;
   logic             up_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] from_ff;
   logic [CNT_W-1:0] steps_ff;
   logic             hit;
   logic             last_step;
   logic [CNT_W-1:0] idx_inc;
   logic [CNT_W-1:0] count_dec;
   logic [IDX_W-1:0] idx_in;

   // One entry is examined per cycle; the sweep gives up after count entries.
   assign hit       = !disabled[idx_ff];
   assign count_dec = count - CNT_W'(1);
   assign last_step = (steps_ff == count_dec);
   assign idx_inc   = CNT_W'(idx_ff) + CNT_W'(1);

   // Wrap-around step in either direction.
   always_comb begin
      if (up_ff) begin
         idx_in = (idx_ff == '0) ? count_dec[IDX_W-1:0] : idx_ff - IDX_W'(1);
      end else begin
         idx_in = (idx_inc == count) ? '0 : idx_inc[IDX_W-1:0];
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (hit || last_step);
   assign result    = hit ? idx_ff : from_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.start) begin
         busy_ff <= 1'b1;
      end else if (stat.done) begin
         busy_ff <= 1'b0;
      end
   end

   // Walk registers carry no reset; they are loaded on every start.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         up_ff    <= cmd.up;
         idx_ff   <= from;
         from_ff  <= from;
         steps_ff <= '0;
      end else if (busy_ff) begin
         idx_ff   <= idx_in;
         steps_ff <= steps_ff + CNT_W'(1);
      end
   end

endmodule
